// ===== sv/isfp_pkg.sv =====
// Package for the IMU serial frame parser: shared constants, codes and types.
// No dependencies; every module of the parser imports it.
package isfp_pkg;

	// frame bytes and type codes
	localparam logic [7:0] HdrByte  = 8'h5A;
	localparam logic [7:0] TypeGyro = 8'hAA;
	localparam logic [7:0] TypeYaw  = 8'hBB;

	// result kinds
	localparam logic KindGyro = 1'b0;
	localparam logic KindYaw  = 1'b1;

	// configuration register indexes
	localparam logic RegGyroScale = 1'b0;
	localparam logic RegYawScale  = 1'b1;

	// field widths
	localparam int ByteW   = 8;
	localparam int ScaleW  = 12;
	localparam int RawW    = 16;
	localparam int ScaledW = 21;
	localparam int CountW  = 32;
	localparam int ProdW   = RawW + ScaleW + 1;
	localparam int FracShift = 7;

	// reset values of the full-scale registers
	localparam logic [ScaleW-1:0] GyroScaleRst = 12'd2000;
	localparam logic [ScaleW-1:0] YawScaleRst  = 12'd180;

	// frame queue
	localparam int QDepth = 4;
	localparam int QPtrW  = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);

	// bytes held in the current frame
	localparam logic [2:0] HeldNone = 3'd0;
	localparam logic [2:0] HeldOne  = 3'd1;
	localparam logic [2:0] HeldTwo  = 3'd2;
	localparam logic [2:0] HeldThree = 3'd3;
	localparam logic [2:0] HeldFour = 3'd4;

	// one validated frame, as passed from front to back
	typedef struct packed {
		logic            kind;
		logic [RawW-1:0] raw;
	} frame_t;

	// queue status seen by the front and back
	typedef struct packed {
		logic full;
		logic not_empty;
	} q_stat_t;

endpackage

// ===== sv/isfp_front.sv =====
// Front end of the frame parser: takes bytes, assembles 5-byte frames,
// checks header, checksum and type, and pushes good frames. Uses isfp_pkg.
module isfp_front
	import isfp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [ByteW-1:0] s_tdata,   // [7:0] rx_byte
	input  q_stat_t          q_stat,
	output logic             push,
	output frame_t           push_frame
);

	logic [2:0]       held_q;
	logic [ByteW-1:0] type_q;
	logic [ByteW-1:0] lo_q;
	logic [ByteW-1:0] hi_q;
	logic             beat;
	logic [ByteW-1:0] sum;
	logic             type_ok;

	// only the checksum beat needs a free queue slot
	assign s_tready = !q_stat.full || (held_q != HeldFour);
	assign beat     = s_tvalid && s_tready;

	// frame check on the checksum beat
	assign sum     = HdrByte + type_q + lo_q + hi_q;
	assign type_ok = (type_q == TypeGyro) || (type_q == TypeYaw);
	assign push    = beat && (held_q == HeldFour) && (sum == s_tdata) && type_ok;

	assign push_frame.kind = (type_q == TypeGyro) ? KindGyro : KindYaw;
	assign push_frame.raw  = {hi_q, lo_q};

	// held byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= HeldNone;
		end else if (beat) begin
			unique case (held_q)
				HeldNone:  held_q <= (s_tdata == HdrByte) ? HeldOne : HeldNone;
				HeldOne:   held_q <= HeldTwo;
				HeldTwo:   held_q <= HeldThree;
				HeldThree: held_q <= HeldFour;
				HeldFour:  held_q <= HeldNone;
				default:   held_q <= (s_tdata == HdrByte) ? HeldOne : HeldNone;
			endcase
		end
	end

	// frame byte store
	always_ff @(posedge clk) begin
		if (beat) begin
			if (held_q == HeldOne)   type_q <= s_tdata;
			if (held_q == HeldTwo)   lo_q   <= s_tdata;
			if (held_q == HeldThree) hi_q   <= s_tdata;
		end
	end

endmodule

// ===== sv/isfp_queue.sv =====
// Short frame queue between front and back of the parser.
// Register-based FIFO of frame_t entries; uses isfp_pkg.
module isfp_queue
	import isfp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  frame_t  push_frame,
	input  logic    pop,
	output frame_t  head,
	output q_stat_t q_stat
);

	frame_t           mem_q [QDepth];
	logic [QPtrW-1:0] wr_q;
	logic [QPtrW-1:0] rd_q;
	logic [QCntW-1:0] cnt_q;

	assign head             = mem_q[rd_q];
	assign q_stat.full      = (cnt_q == QCntW'(QDepth));
	assign q_stat.not_empty = (cnt_q != '0);

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_frame;
	end

endmodule

// ===== sv/isfp_back.sv =====
// Back end of the frame parser: scales frames in a two-stage pipeline
// (multiply, then shift and count) into the output register. Uses isfp_pkg.
module isfp_back
	import isfp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  q_stat_t           q_stat,
	input  frame_t            head,
	output logic              pop,
	input  logic [ScaleW-1:0] gyro_scale,
	input  logic [ScaleW-1:0] yaw_scale,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              out_kind,
	output logic [RawW-1:0]   out_raw,
	output logic [ScaledW-1:0] out_scaled,
	output logic [CountW-1:0] out_count
);

	logic                    vld_s1;
	logic                    kind_s1;
	logic [RawW-1:0]         raw_s1;
	logic signed [ProdW-1:0] prod_s1;
	logic                    vld_q;
	logic [CountW-1:0]       count_q;
	logic                    out_en;
	logic                    s1_en;
	logic [ScaleW-1:0]       scale_sel;
	logic signed [ProdW-1:0] prod;
	logic [CountW-1:0]       count_nxt;

	// stall chain from the output back to the queue
	assign out_en = !vld_q || out_ready;
	assign s1_en  = !vld_s1 || out_en;
	assign pop    = q_stat.not_empty && s1_en;

	// stage 1: signed raw times unsigned scale
	assign scale_sel = (head.kind == KindGyro) ? gyro_scale : yaw_scale;
	assign prod      = ProdW'($signed(head.raw)) * ProdW'($signed({1'b0, scale_sel}));

	// gyro count including this frame
	assign count_nxt = count_q + CountW'(kind_s1 == KindGyro);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_q   <= 1'b0;
			count_q <= '0;
		end else begin
			if (s1_en) vld_s1 <= pop;
			if (out_en) begin
				vld_q <= vld_s1;
				if (vld_s1) count_q <= count_nxt;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (pop) begin
			kind_s1 <= head.kind;
			raw_s1  <= head.raw;
			prod_s1 <= prod;
		end
		if (out_en && vld_s1) begin
			out_kind   <= kind_s1;
			out_raw    <= raw_s1;
			// floor divide by 128: drop the low bits of the two's complement product
			out_scaled <= prod_s1[FracShift +: ScaledW];
			out_count  <= count_nxt;
		end
	end

	assign out_valid = vld_q;

endmodule

// ===== sv/imu_serial_frame_parser_core.sv =====
// Top level of the IMU serial frame parser: front, frame queue, back and the
// full-scale registers. Uses isfp_pkg, isfp_front, isfp_queue, isfp_back.
//
//  channel  | direction | beat contents
//  ---------+-----------+-----------------------------------------------------
//  s_axis   | in        | tdata[7:0] rx_byte
//  m_axis   | out       | tuser[0] frame_kind; tdata raw_value, scaled_value,
//           |           | gyro_frames, zero pad
//  cfg      | in        | cfg_idx 0 gyro_full_scale, 1 yaw_full_scale
//
// One byte is taken every cycle; the only stall on the input is a full frame
// queue when a checksum byte arrives. After its queue write, a good frame's result
// passes the multiply stage, then the output register.
// Reset clears the byte count, the queue, the pipeline valids, the gyro count
// and loads the full-scale registers with 2000 and 180.
// The four-entry queue lets the input keep running while the output stalls.
module imu_serial_frame_parser_core
	import isfp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // [7:0] rx_byte
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [71:0]       m_tdata,   // [15:0] raw_value, [36:16] scaled_value,
	                                     // [68:37] gyro_frames, [71:69] zero
	output logic [0:0]        m_tuser,   // [0] frame_kind
	input  logic              cfg_we,
	input  logic [0:0]        cfg_idx,
	input  logic [ScaleW-1:0] cfg_data
);

	logic [ScaleW-1:0]  gyro_scale_q;
	logic [ScaleW-1:0]  yaw_scale_q;
	q_stat_t            q_stat;
	logic               push;
	frame_t             push_frame;
	logic               pop;
	frame_t             head;
	logic               out_kind;
	logic [RawW-1:0]    out_raw;
	logic [ScaledW-1:0] out_scaled;
	logic [CountW-1:0]  out_count;

	// full-scale registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gyro_scale_q <= GyroScaleRst;
			yaw_scale_q  <= YawScaleRst;
		end else if (cfg_we) begin
			unique case (cfg_idx[0])
				RegGyroScale: gyro_scale_q <= cfg_data;
				RegYawScale:  yaw_scale_q  <= cfg_data;
				default:      ;
			endcase
		end
	end

	isfp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.q_stat     (q_stat),
		.push       (push),
		.push_frame (push_frame)
	);

	isfp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_frame (push_frame),
		.pop        (pop),
		.head       (head),
		.q_stat     (q_stat)
	);

	isfp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_stat     (q_stat),
		.head       (head),
		.pop        (pop),
		.gyro_scale (gyro_scale_q),
		.yaw_scale  (yaw_scale_q),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_kind   (out_kind),
		.out_raw    (out_raw),
		.out_scaled (out_scaled),
		.out_count  (out_count)
	);

	// output beat packing
	assign m_tdata    = {3'b000, out_count, out_scaled, out_raw};
	assign m_tuser[0] = out_kind;

endmodule
